// ===== rtl/sngf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, prime ROM and reciprocal ROM for the smooth number gap finder.
package sngf_pkg;

  localparam int MAX_K      = 256;
  localparam int NUM_PRIMES = 54;
  localparam int KW         = $clog2(MAX_K + 1);
  localparam int IW         = $clog2(NUM_PRIMES + 1);
  localparam int RW         = (NUM_PRIMES > 1) ? $clog2(NUM_PRIMES) : 1;
  localparam int DEF_WINDOW = 200;

  typedef logic [KW-1:0] prime_arr_t [NUM_PRIMES];
  typedef logic [63:0]   inv_arr_t   [NUM_PRIMES];

  typedef struct packed {
    logic [63:0] number;
    logic        restart;
    logic        is_zero;
  } item_t;

  function automatic prime_arr_t build_primes();
    prime_arr_t       res;
    logic [MAX_K:0]   comp;
    int               cnt;
    comp = '0;
    cnt  = 0;
    for (int i = 0; i < NUM_PRIMES; i++) res[i] = '1;
    for (int i = 2; i <= MAX_K; i++) begin
      if (!comp[i]) begin
        if (cnt < NUM_PRIMES) begin
          res[cnt] = KW'(i);
          cnt      = cnt + 1;
        end
        for (int j = i * i; j <= MAX_K; j += i) comp[j] = 1'b1;
      end
    end
    return res;
  endfunction

  localparam prime_arr_t PRIMES = build_primes();

  // inverse of each odd prime modulo 2^64, by Newton steps
  function automatic inv_arr_t build_inv();
    inv_arr_t    res;
    logic [63:0] p;
    logic [63:0] v;
    for (int i = 0; i < NUM_PRIMES; i++) begin
      p = 64'(PRIMES[i]);
      v = p;
      for (int s = 0; s < 6; s++) v = v * (64'd2 - p * v);
      res[i] = v;
    end
    return res;
  endfunction

  localparam inv_arr_t INVS = build_inv();

  function automatic logic [3:0] low_zeros(input logic [7:0] b);
    logic [3:0] n;
    n = 4'd8;
    for (int i = 7; i >= 0; i--) if (b[i]) n = 4'(i);
    return n;
  endfunction

endpackage

// ===== rtl/smooth_number_gap_finder.sv =====
`timescale 1ns / 1ps
// Top level of the smooth number gap finder: stream ports, APB register, front and back.
//
// Input stream: s_axis_tdata carries the number to test, s_axis_tuser the
// restart flag that clears the window history ahead of that number.
// Output stream: one transaction per input with is_smooth, gap_found and
// gap_start (number minus k when a gap is found, else zero).
// APB register at byte 0: window_len (k), reset value 200; the user is to write it only
// while idle, which the block itself does not enforce. Each transaction strips factors of
// two in shift steps of up to eight, then tests each odd prime up to k and strips each
// factor found, using the shared 32x32 multiplier that forms the reciprocal product.
// Up to two inputs queue ahead.
// Reset clears the queue, the window flags, the seen counter and the output.
// A stalled receiver holds the result register; the queue keeps accepting
// until full, then s_axis_tready drops.
module smooth_number_gap_finder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // number
  input  logic        s_axis_tuser,   // restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // is_smooth, gap_found, gap_start[63:0], zero pad
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int KW = sngf_pkg::KW;

  logic [8:0]      wlen_q;
  logic [KW-1:0]   k;
  logic            item_valid, item_ready;
  sngf_pkg::item_t item;
  logic            o_smooth, o_gap;
  logic [63:0]     o_start;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {23'd0, wlen_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= 9'(sngf_pkg::DEF_WINDOW);
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      wlen_q <= pwdata[8:0];
    end
  end

  always_comb begin
    if (wlen_q == 9'd0) k = KW'(1);
    else if (KW'(wlen_q) > KW'(sngf_pkg::MAX_K)) k = KW'(sngf_pkg::MAX_K);
    else k = KW'(wlen_q);
  end

  sngf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_number_i  (s_axis_tdata),
    .in_restart_i (s_axis_tuser),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  sngf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .k_i          (k),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_smooth_o (o_smooth),
    .out_gap_o    (o_gap),
    .out_start_o  (o_start)
  );

  assign m_axis_tdata = {6'd0, o_start, o_gap, o_smooth};

  a_gap_not_smooth : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && o_gap |-> !o_smooth) else $error("gap with smooth number");

  a_start_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !o_gap |-> o_start == 64'd0) else $error("gap_start without gap");

  a_cfg_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && !paddr[2] |=> wlen_q == $past(pwdata[8:0]))
    else $error("window_len write lost");

endmodule

// ===== rtl/sngf_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts input transactions, tags zero, and queues them.
module sngf_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [63:0]     in_number_i,
  input  logic            in_restart_i,
  output logic            item_valid_o,
  input  logic            item_ready_i,
  output sngf_pkg::item_t item_o
);

  sngf_pkg::item_t mem_q [2];
  logic            wp_q, wp_d, rp_q, rp_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            push, pop;

  assign in_ready_o   = (cnt_q != 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = mem_q[rp_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_valid_o && item_ready_i;

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q].number  <= in_number_i;
      mem_q[wp_q].restart <= in_restart_i;
      mem_q[wp_q].is_zero <= (in_number_i == 64'd0);
    end
  end

endmodule

// ===== rtl/sngf_back.sv =====
`timescale 1ns / 1ps
// Back end: strips prime factors, updates the smooth window, holds the result.
module sngf_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [sngf_pkg::KW-1:0] k_i,
  input  logic                   item_valid_i,
  output logic                   item_ready_o,
  input  sngf_pkg::item_t        item_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   out_smooth_o,
  output logic                   out_gap_o,
  output logic [63:0]            out_start_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PRIME = 4'd1;
  localparam logic [3:0] S_TWO   = 4'd2;
  localparam logic [3:0] S_M0    = 4'd3;
  localparam logic [3:0] S_M1    = 4'd4;
  localparam logic [3:0] S_M2    = 4'd5;
  localparam logic [3:0] S_M3    = 4'd6;
  localparam logic [3:0] S_CHK   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  localparam int KW = sngf_pkg::KW;
  localparam int IW = sngf_pkg::IW;
  localparam int RW = sngf_pkg::RW;

  logic [3:0]              st_q, st_d;
  logic [IW-1:0]           idx_q, idx_d;
  logic [63:0]             x_q, x_d, num_q, num_d, acc_q, acc_d, q_q, q_d;
  logic [63:0]             mul_q, mul_d;
  logic                    rst_q, rst_d;
  logic [sngf_pkg::MAX_K-1:0] win_q, win_d;
  logic [KW-1:0]           seen_q, seen_d;
  logic                    ov_q, ov_d, os_q, os_d, og_q, og_d;
  logic [63:0]             ost_q, ost_d;

  logic [RW-1:0]           ridx;
  logic [KW-1:0]           p;
  logic [63:0]             inv;
  logic [31:0]             ma, mb;
  logic [KW+63:0]          chk;
  logic [3:0]              tz;
  logic                    out_free, smooth, none;
  logic [sngf_pkg::MAX_K-1:0] wbase, wnew, mask;
  logic [KW-1:0]           sclamp, snew;

  assign ridx     = idx_q[RW-1:0];
  assign p        = sngf_pkg::PRIMES[ridx];
  assign inv      = sngf_pkg::INVS[ridx];
  assign out_free = !ov_q || out_ready_i;
  assign tz       = sngf_pkg::low_zeros(x_q[7:0]);
  assign chk      = q_q * {{64{1'b0}}, p};
  assign item_ready_o = (st_q == S_IDLE);

  always_comb begin
    case (st_q)
      S_M0:    begin ma = x_q[31:0];  mb = inv[31:0];  end
      S_M1:    begin ma = x_q[63:32]; mb = inv[31:0];  end
      default: begin ma = x_q[31:0];  mb = inv[63:32]; end
    endcase
  end
  assign mul_d = 64'(ma) * 64'(mb);

  always_comb begin
    for (int i = 0; i < sngf_pkg::MAX_K; i++) mask[i] = (KW'(i) < k_i);
    smooth = (x_q == 64'd1);
    wbase  = rst_q ? '0 : win_q;
    wnew   = {wbase[sngf_pkg::MAX_K-2:0], smooth};
    none   = ((wnew & mask) == '0);
    sclamp = rst_q ? '0 : ((seen_q > k_i) ? k_i : seen_q);
    snew   = (sclamp < k_i) ? sclamp + KW'(1) : sclamp;
  end

  always_comb begin
    st_d   = st_q;
    idx_d  = idx_q;
    x_d    = x_q;
    num_d  = num_q;
    rst_d  = rst_q;
    acc_d  = acc_q;
    q_d    = q_q;
    win_d  = win_q;
    seen_d = seen_q;
    ov_d   = ov_q && !out_ready_i;
    os_d   = os_q;
    og_d   = og_q;
    ost_d  = ost_q;
    case (st_q)
      S_IDLE: begin
        if (item_valid_i) begin
          x_d   = item_i.number;
          num_d = item_i.number;
          rst_d = item_i.restart;
          idx_d = '0;
          st_d  = item_i.is_zero ? S_DONE : S_PRIME;
        end
      end
      S_PRIME: begin
        if (idx_q == IW'(sngf_pkg::NUM_PRIMES) || p > k_i) st_d = S_DONE;
        else if (idx_q == '0) st_d = S_TWO;
        else st_d = S_M0;
      end
      S_TWO: begin
        if (x_q[0]) begin
          idx_d = IW'(1);
          st_d  = S_PRIME;
        end else begin
          x_d = x_q >> tz;
        end
      end
      S_M0: st_d = S_M1;
      S_M1: begin
        acc_d = mul_q;
        st_d  = S_M2;
      end
      S_M2: begin
        acc_d = acc_q + {mul_q[31:0], 32'd0};
        st_d  = S_M3;
      end
      S_M3: begin
        q_d  = acc_q + {mul_q[31:0], 32'd0};
        st_d = S_CHK;
      end
      S_CHK: begin
        if (chk[KW+63:64] == '0) begin
          x_d  = q_q;
          st_d = S_M0;
        end else begin
          idx_d = idx_q + IW'(1);
          st_d  = S_PRIME;
        end
      end
      S_DONE: begin
        if (out_free) begin
          win_d  = wnew;
          seen_d = snew;
          ov_d   = 1'b1;
          os_d   = smooth;
          og_d   = (snew == k_i) && none;
          ost_d  = ((snew == k_i) && none) ? num_q - 64'(k_i) : 64'd0;
          st_d   = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      win_q  <= '0;
      seen_q <= '0;
      ov_q   <= 1'b0;
    end else begin
      st_q   <= st_d;
      win_q  <= win_d;
      seen_q <= seen_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    x_q   <= x_d;
    num_q <= num_d;
    rst_q <= rst_d;
    acc_q <= acc_d;
    q_q   <= q_d;
    mul_q <= mul_d;
    os_q  <= os_d;
    og_q  <= og_d;
    ost_q <= ost_d;
  end

  assign out_valid_o  = ov_q;
  assign out_smooth_o = os_q;
  assign out_gap_o    = og_q;
  assign out_start_o  = ost_q;

endmodule

// ===== sim/smooth_number_gap_finder_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the smooth number gap finder: directed table, random runs, predictor.
module smooth_number_gap_finder_tb;

  localparam int WDOG_LIMIT = 200000;
  localparam logic [2:0] ADDR_WINDOW_LEN = 3'd0;

  typedef struct {
    logic [63:0] number;
    logic        restart;
    logic        chk;
    logic        smooth;
    logic        gap;
    logic [63:0] start;
  } row_t;

  typedef struct packed {
    logic        smooth;
    logic        gap;
    logic [63:0] start;
  } verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  smooth_number_gap_finder DUT (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  logic [sngf_pkg::MAX_K-1:0] flag_hist = '0;
  int unsigned      seen_cnt = 0;
  logic [8:0]       k_reg = 9'd200;

  verdict_t    verdicts_due[$];
  verdict_t    typed_due[$];
  logic        typed_valid[$];
  int unsigned n_err = 0;
  int unsigned wdog = 0;
  bit          calm = 1'b0;
  bit          rx_stall_ok = 1'b1;

  function automatic int unsigned k_eff(input logic [8:0] w);
    if (w < 1) return 1;
    if (w > sngf_pkg::MAX_K) return sngf_pkg::MAX_K;
    return w;
  endfunction

  function automatic bit is_prime(input int unsigned p);
    for (int unsigned d = 2; d * d <= p; d++) if (p % d == 0) return 1'b0;
    return p >= 2;
  endfunction

  function automatic bit smooth_under(input logic [63:0] n, input int unsigned k);
    logic [63:0] x;
    x = n;
    if (x == 0) return 1'b0;
    for (int unsigned p = 2; p <= k; p++) begin
      if (is_prime(p)) while (x % p == 0) x = x / p;
    end
    return x == 1;
  endfunction

  function automatic verdict_t judge_number(input logic [63:0] n, input logic rs);
    verdict_t    v;
    int unsigned k;
    int unsigned cnt;
    k = k_eff(k_reg);
    if (rs) begin
      flag_hist = '0;
      seen_cnt  = 0;
    end
    v.smooth  = smooth_under(n, k);
    flag_hist = {flag_hist[sngf_pkg::MAX_K-2:0], v.smooth};
    cnt = 0;
    for (int unsigned i = 0; i < k; i++) cnt += flag_hist[i];
    if (seen_cnt < k) seen_cnt++;
    if (seen_cnt > k) seen_cnt = k;
    v.gap   = (seen_cnt >= k) && (cnt == 0);
    v.start = v.gap ? n - 64'(k) : 64'd0;
    return v;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    verdict_t got;
    verdict_t want;
    logic     has_typed;
    verdict_t typed;
    if (s_axis_tvalid && s_axis_tready) wdog <= 0;
    else if (m_axis_tvalid && m_axis_tready) wdog <= 0;
    else wdog <= wdog + 1;
    if (m_axis_tvalid && m_axis_tready) begin
      got.smooth = m_axis_tdata[0];
      got.gap    = m_axis_tdata[1];
      got.start  = m_axis_tdata[65:2];
      if (verdicts_due.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected transaction %h", m_axis_tdata);
      end else begin
        want      = verdicts_due.pop_front();
        typed     = typed_due.pop_front();
        has_typed = typed_valid.pop_front();
        if (got !== want || (has_typed && got !== typed)) begin
          n_err++;
          if (n_err <= 10)
            $display({"mismatch: exp s=%0b g=%0b st=%h (table s=%0b g=%0b st=%h)",
                      " got s=%0b g=%0b st=%h"},
                     want.smooth, want.gap, want.start, typed.smooth, typed.gap, typed.start,
                     got.smooth, got.gap, got.start);
        end
      end
    end
    if (wdog >= WDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver stalls in bursts
  initial begin
    int unsigned gap;
    forever begin
      @(posedge clk_i);
      if (!calm && rx_stall_ok && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        gap = $urandom_range(1, 8);
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  task automatic write_window(input logic [8:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_WINDOW_LEN;
    pwdata  <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    k_reg = val;
  endtask

  task automatic drain();
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (6000) @(posedge clk_i);
  endtask

  task automatic send_number(input logic [63:0] n, input logic rs, input logic chk,
                             input verdict_t typed);
    int unsigned gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= n;
    s_axis_tuser  <= rs;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    verdicts_due.push_back(judge_number(n, rs));
    typed_due.push_back(typed);
    typed_valid.push_back(chk);
  endtask

  task automatic run_block(input logic [63:0] base, input int unsigned len, input bit rs_first);
    for (int unsigned i = 0; i < len; i++) begin
      logic rs;
      rs = (i == 0) ? rs_first : ($urandom_range(0, 199) == 0);
      send_number(base + 64'(i), rs, 1'b0, '0);
    end
  endtask

  row_t dir_rows[] = '{
    '{64'd1,   1'b1, 1'b1, 1'b1, 1'b0, 64'd0},
    '{64'd0,   1'b0, 1'b1, 1'b0, 1'b0, 64'd0},
    '{64'd2,   1'b0, 1'b1, 1'b1, 1'b0, 64'd0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
    '{64'h8000_0000_0000_0000, 1'b0, 1'b1, 1'b1, 1'b0, 64'd0},
    '{64'd251, 1'b0, 1'b1, 1'b0, 1'b0, 64'd0},
    '{64'd257, 1'b0, 1'b1, 1'b0, 1'b0, 64'd0},
    '{64'd65536, 1'b0, 1'b1, 1'b1, 1'b0, 64'd0},
    '{64'hFFFF_FFFF_FFFF_FFC5, 1'b0, 1'b0, 1'b0, 1'b0, 64'd0},
    '{64'd43046721, 1'b0, 1'b1, 1'b1, 1'b0, 64'd0}
  };

  initial begin
    logic [63:0] base;
    verdict_t    typed;
    int unsigned kk;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      typed = '{dir_rows[i].smooth, dir_rows[i].gap, dir_rows[i].start};
      send_number(dir_rows[i].number, dir_rows[i].restart, dir_rows[i].chk, typed);
    end
    s_axis_tvalid <= 1'b0;
    drain();

    // k = 1: only one is smooth, gap on every other number
    write_window(9'd1);
    send_number(64'd5, 1'b1, 1'b1, '{1'b0, 1'b1, 64'd4});
    send_number(64'd1, 1'b0, 1'b1, '{1'b1, 1'b0, 64'd0});
    send_number(64'd0, 1'b0, 1'b1, '{1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF});
    s_axis_tvalid <= 1'b0;
    drain();
    write_window(9'd0);
    run_block(64'd1, 6, 1'b1);
    s_axis_tvalid <= 1'b0;
    drain();
    write_window(9'd511);
    run_block(64'd1000, 5, 1'b0);
    s_axis_tvalid <= 1'b0;
    drain();

    // random phases over several settings
    for (int ph = 0; ph < 14; ph++) begin
      case (ph % 7)
        0: kk = 2;
        1: kk = 3;
        2: kk = 5;
        3: kk = $urandom_range(2, 12);
        4: kk = $urandom_range(13, 40);
        5: kk = 256;
        default: kk = $urandom_range(0, 511);
      endcase
      write_window(9'(kk));
      if (ph == 13) calm = 1'b1;
      case ($urandom_range(0, 3))
        0: base = {$urandom, $urandom};
        1: base = 64'd0 - 64'($urandom_range(1, 60));
        2: base = 64'($urandom_range(1, 5000));
        default: base = {$urandom_range(0, 3), $urandom};
      endcase
      run_block(base, (kk > 64 && kk != 511) ? 60 : 135, 1'b1);
      // noise: broken sequences with random content
      for (int j = 0; j < 5; j++)
        send_number({$urandom, $urandom}, 1'($urandom_range(0, 1)), 1'b0, '0);
      if (ph == 4) begin
        s_axis_tvalid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b0;
      drain();
    end

    if (n_err == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
